@@ design/qrs_pkg.sv @@
// ----------------------------------------------------------------------------
// qrs_pkg: shared constants and types of the quadratic root solver
// Number format, derived datapath widths, root kind codes and the
// sideband records that travel down the pipeline with each transaction.
// ----------------------------------------------------------------------------
package qrs_pkg;

  // number format of coefficients and roots
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // derived widths
  localparam int PROD_W = 2 * DATA_WIDTH;       // b*b and a*c
  localparam int DISC_W = 2 * DATA_WIDTH + 2;   // discriminant magnitude
  localparam int SQRT_N = DISC_W / 2;           // square root stages
  localparam int ROOT_W = SQRT_N;               // square root width
  localparam int SREM_W = ROOT_W + 2;           // square root remainder
  localparam int NUM_W  = DATA_WIDTH + 2;       // divider numerator
  localparam int QUO_W  = NUM_W + FRAC_BITS;    // divider quotient / stages
  localparam int DEN_W  = DATA_WIDTH + 1;       // divider divisor

  // cycles from accept edge to the sample after the result strobe
  localparam int LATENCY = SQRT_N + QUO_W + 5;

  typedef logic [DATA_WIDTH-1:0] qrs_mag_t;

  // root kind codes
  typedef enum logic [2:0] {
    KIND_TWO_REAL = 3'd0,
    KIND_DOUBLE   = 3'd1,
    KIND_COMPLEX  = 3'd2,
    KIND_LINEAR   = 3'd3,
    KIND_NONE     = 3'd4
  } qrs_kind_t;

  // sideband through decode, products and square root
  typedef struct packed {
    logic     na;
    logic     nb;
    logic     nc;
    logic     lin;
    logic     nosol;
    logic     dneg;
    logic     dzero;
    qrs_mag_t am;
    qrs_mag_t bm;
    qrs_mag_t cm;
  } qrs_sq_sb_t;

  // sideband through the divider
  typedef struct packed {
    logic             na;
    logic             lin;
    logic             nosol;
    logic             dneg;
    logic             dzero;
    logic             sgn_a;
    logic             sgn_b;
    logic [DEN_W-1:0] den;
  } qrs_dv_sb_t;

endpackage

@@ design/quadratic_root_solver.sv @@
// ----------------------------------------------------------------------------
// quadratic_root_solver: fixed-point roots of a*x^2 + b*x + c
// Fully pipelined; takes one coefficient set per clock and never blocks.
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge with start high (busy is always
// low) and its result is shown for one cycle with out_valid after passing, in
// order, through decode, two products, the discriminant, DATA_WIDTH + 1
// square root stages (one root bit each), a numerator set-up stage,
// DATA_WIDTH + FRAC_BITS + 2 restoring divider stages (one quotient bit
// each, two lanes sharing the divisor) and the output register. Results
// leave in accept order, one per cycle at most; the receiver cannot stall,
// so none must be refused downstream.
module quadratic_root_solver (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] in_coef_a,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] in_coef_b,
  input  logic signed [qrs_pkg::DATA_WIDTH-1:0] in_coef_c,
  output logic                                 out_valid,
  output logic signed [qrs_pkg::DATA_WIDTH-1:0] out_root1_real,
  output logic signed [qrs_pkg::DATA_WIDTH-1:0] out_root1_imag,
  output logic signed [qrs_pkg::DATA_WIDTH-1:0] out_root2_real,
  output logic signed [qrs_pkg::DATA_WIDTH-1:0] out_root2_imag,
  output logic [2:0]                           out_root_kind,
  output logic                                 out_saturated
);

  localparam int W = qrs_pkg::DATA_WIDTH;

  // saturate one root part, returns {clipped, value}
  function automatic logic [W:0] emit_part(input logic neg_in,
                                           input logic [qrs_pkg::QUO_W-1:0] q);
    logic                      neg;
    logic [qrs_pkg::QUO_W-1:0] lim;
    logic                      clip;
    logic [W-1:0]              v;
    neg  = neg_in && (q != '0);
    lim  = neg ? (qrs_pkg::QUO_W'(1) << (W - 1))
               : ((qrs_pkg::QUO_W'(1) << (W - 1)) - qrs_pkg::QUO_W'(1));
    clip = q > lim;
    v    = clip ? lim[W-1:0] : q[W-1:0];
    return {clip, neg ? (-v) : v};
  endfunction

  logic accept;

  // never blocks
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // stage a: linear and no-solution flags, sign and magnitude of each coefficient
  // --------------------------------------------------------------------------
  logic                a_v_r;
  qrs_pkg::qrs_sq_sb_t a_sb_r, a_sb_nxt;

  always_comb begin
    a_sb_nxt       = '0;
    a_sb_nxt.na    = in_coef_a[W-1];
    a_sb_nxt.nb    = in_coef_b[W-1];
    a_sb_nxt.nc    = in_coef_c[W-1];
    a_sb_nxt.am    = in_coef_a[W-1] ? W'(-in_coef_a) : W'(in_coef_a);
    a_sb_nxt.bm    = in_coef_b[W-1] ? W'(-in_coef_b) : W'(in_coef_b);
    a_sb_nxt.cm    = in_coef_c[W-1] ? W'(-in_coef_c) : W'(in_coef_c);
    a_sb_nxt.lin   = (a_sb_nxt.am == '0);
    a_sb_nxt.nosol = (a_sb_nxt.am == '0) && (a_sb_nxt.bm == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
    end
    a_sb_r <= a_sb_nxt;
  end

  // --------------------------------------------------------------------------
  // stage b: b*b and a*c
  // --------------------------------------------------------------------------
  logic                       b_v_r;
  qrs_pkg::qrs_sq_sb_t        b_sb_r;
  logic [qrs_pkg::PROD_W-1:0] b_bb_r, b_bb_nxt;
  logic [qrs_pkg::PROD_W-1:0] b_ac_r, b_ac_nxt;

  always_comb begin
    b_bb_nxt = qrs_pkg::PROD_W'(a_sb_r.bm) * qrs_pkg::PROD_W'(a_sb_r.bm);
    b_ac_nxt = qrs_pkg::PROD_W'(a_sb_r.am) * qrs_pkg::PROD_W'(a_sb_r.cm);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else begin
      b_v_r <= a_v_r;
    end
    b_sb_r <= a_sb_r;
    b_bb_r <= b_bb_nxt;
    b_ac_r <= b_ac_nxt;
  end

  // --------------------------------------------------------------------------
  // stage c: discriminant b*b - 4ac as sign and magnitude
  // --------------------------------------------------------------------------
  logic                       sq_v_r    [qrs_pkg::SQRT_N+1];
  qrs_pkg::qrs_sq_sb_t        sq_sb_r   [qrs_pkg::SQRT_N+1];
  logic [qrs_pkg::DISC_W-1:0] sq_d_r    [qrs_pkg::SQRT_N+1];
  logic [qrs_pkg::SREM_W-1:0] sq_rem_r  [qrs_pkg::SQRT_N+1];
  logic [qrs_pkg::ROOT_W-1:0] sq_root_r [qrs_pkg::SQRT_N+1];

  logic [qrs_pkg::DISC_W-1:0] c_bbx, c_ac4, c_sum, c_dif1, c_dif2, c_d_nxt;
  logic                       c_acneg;
  qrs_pkg::qrs_sq_sb_t        c_sb_nxt;

  always_comb begin
    c_bbx    = qrs_pkg::DISC_W'(b_bb_r);
    c_ac4    = qrs_pkg::DISC_W'(b_ac_r) << 2;
    c_sum    = c_bbx + c_ac4;
    c_dif1   = c_bbx - c_ac4;
    c_dif2   = c_ac4 - c_bbx;
    c_acneg  = (b_sb_r.na != b_sb_r.nc) && (b_sb_r.cm != '0);
    c_sb_nxt = b_sb_r;
    if (c_acneg) begin
      c_d_nxt        = c_sum;
      c_sb_nxt.dneg  = 1'b0;
    end else if (c_bbx >= c_ac4) begin
      c_d_nxt        = c_dif1;
      c_sb_nxt.dneg  = 1'b0;
    end else begin
      c_d_nxt        = c_dif2;
      c_sb_nxt.dneg  = 1'b1;
    end
    c_sb_nxt.dzero = (c_d_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else begin
      sq_v_r[0] <= b_v_r;
    end
    sq_sb_r[0]   <= c_sb_nxt;
    sq_d_r[0]    <= c_d_nxt;
    sq_rem_r[0]  <= '0;
    sq_root_r[0] <= '0;
  end

  // --------------------------------------------------------------------------
  // square root: one root bit per stage, two discriminant bits consumed
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= qrs_pkg::SQRT_N; k++) begin : g_sqrt
    logic [qrs_pkg::SREM_W+1:0] rem_sh, trial, dif;
    logic                       ge;

    always_comb begin
      rem_sh = {sq_rem_r[k-1], sq_d_r[k-1][qrs_pkg::DISC_W-1 -: 2]};
      trial  = {2'b00, sq_root_r[k-1], 2'b01};
      dif    = rem_sh - trial;
      ge     = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[k] <= 1'b0;
      end else begin
        sq_v_r[k] <= sq_v_r[k-1];
      end
      sq_sb_r[k]   <= sq_sb_r[k-1];
      sq_d_r[k]    <= sq_d_r[k-1] << 2;
      sq_rem_r[k]  <= ge ? dif[qrs_pkg::SREM_W-1:0] : rem_sh[qrs_pkg::SREM_W-1:0];
      sq_root_r[k] <= {sq_root_r[k-1][qrs_pkg::ROOT_W-2:0], ge};
    end
  end

  // --------------------------------------------------------------------------
  // stage p: numerators, divisor and result signs per case
  // --------------------------------------------------------------------------
  logic                       dv_v_r    [qrs_pkg::QUO_W+1];
  qrs_pkg::qrs_dv_sb_t        dv_sb_r   [qrs_pkg::QUO_W+1];
  logic [qrs_pkg::QUO_W-1:0]  dv_numa_r [qrs_pkg::QUO_W+1];
  logic [qrs_pkg::QUO_W-1:0]  dv_numb_r [qrs_pkg::QUO_W+1];
  logic [qrs_pkg::DEN_W-1:0]  dv_rema_r [qrs_pkg::QUO_W+1];
  logic [qrs_pkg::DEN_W-1:0]  dv_remb_r [qrs_pkg::QUO_W+1];
  logic [qrs_pkg::QUO_W-1:0]  dv_quoa_r [qrs_pkg::QUO_W+1];
  logic [qrs_pkg::QUO_W-1:0]  dv_quob_r [qrs_pkg::QUO_W+1];

  qrs_pkg::qrs_sq_sb_t       p_sb;
  qrs_pkg::qrs_dv_sb_t       p_sb_nxt;
  logic [qrs_pkg::NUM_W-1:0] p_s, p_b, p_sum, p_bms, p_smb, p_r1, p_r2, p_numa, p_numb;
  logic                      p_mb, p_bge, p_rn1, p_rn2;

  always_comb begin
    p_sb  = sq_sb_r[qrs_pkg::SQRT_N];
    p_s   = qrs_pkg::NUM_W'(sq_root_r[qrs_pkg::SQRT_N]);
    p_b   = qrs_pkg::NUM_W'(p_sb.bm);
    p_mb  = !p_sb.nb && (p_sb.bm != '0);
    p_sum = p_b + p_s;
    p_bms = p_b - p_s;
    p_smb = p_s - p_b;
    p_bge = p_b >= p_s;
    // -b + sqrt(d)
    if (!p_mb) begin
      p_r1 = p_sum; p_rn1 = 1'b0;
    end else if (p_bge) begin
      p_r1 = p_bms; p_rn1 = 1'b1;
    end else begin
      p_r1 = p_smb; p_rn1 = 1'b0;
    end
    // -b - sqrt(d)
    if (p_mb) begin
      p_r2 = p_sum; p_rn2 = 1'b1;
    end else if (p_bge) begin
      p_r2 = p_bms; p_rn2 = 1'b0;
    end else begin
      p_r2 = p_smb; p_rn2 = 1'b1;
    end
    p_sb_nxt       = '0;
    p_sb_nxt.na    = p_sb.na;
    p_sb_nxt.lin   = p_sb.lin;
    p_sb_nxt.nosol = p_sb.nosol;
    p_sb_nxt.dneg  = p_sb.dneg;
    p_sb_nxt.dzero = p_sb.dzero;
    if (p_sb.lin) begin
      p_numa         = qrs_pkg::NUM_W'(p_sb.cm);
      p_numb         = '0;
      p_sb_nxt.sgn_a = (p_sb.nc == p_sb.nb);
      p_sb_nxt.sgn_b = 1'b0;
      p_sb_nxt.den   = qrs_pkg::DEN_W'(p_sb.bm);
    end else if (p_sb.dneg) begin
      p_numa         = p_b;
      p_numb         = p_s;
      p_sb_nxt.sgn_a = (p_mb != p_sb.na);
      p_sb_nxt.sgn_b = p_sb.na;
      p_sb_nxt.den   = {p_sb.am, 1'b0};
    end else begin
      p_numa         = p_r1;
      p_numb         = p_r2;
      p_sb_nxt.sgn_a = (p_rn1 != p_sb.na);
      p_sb_nxt.sgn_b = (p_rn2 != p_sb.na);
      p_sb_nxt.den   = {p_sb.am, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else begin
      dv_v_r[0] <= sq_v_r[qrs_pkg::SQRT_N];
    end
    dv_sb_r[0]   <= p_sb_nxt;
    dv_numa_r[0] <= qrs_pkg::QUO_W'(p_numa) << qrs_pkg::FRAC_BITS;
    dv_numb_r[0] <= qrs_pkg::QUO_W'(p_numb) << qrs_pkg::FRAC_BITS;
    dv_rema_r[0] <= '0;
    dv_remb_r[0] <= '0;
    dv_quoa_r[0] <= '0;
    dv_quob_r[0] <= '0;
  end

  // --------------------------------------------------------------------------
  // restoring divider: one quotient bit per stage, two lanes
  // --------------------------------------------------------------------------
  for (genvar j = 1; j <= qrs_pkg::QUO_W; j++) begin : g_div
    logic [qrs_pkg::DEN_W:0] dext, rsha, rshb, dfa, dfb;
    logic                    gea, geb;

    always_comb begin
      dext = {1'b0, dv_sb_r[j-1].den};
      rsha = {dv_rema_r[j-1], dv_numa_r[j-1][qrs_pkg::QUO_W-1]};
      rshb = {dv_remb_r[j-1], dv_numb_r[j-1][qrs_pkg::QUO_W-1]};
      dfa  = rsha - dext;
      dfb  = rshb - dext;
      gea  = rsha >= dext;
      geb  = rshb >= dext;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[j] <= 1'b0;
      end else begin
        dv_v_r[j] <= dv_v_r[j-1];
      end
      dv_sb_r[j]   <= dv_sb_r[j-1];
      dv_numa_r[j] <= dv_numa_r[j-1] << 1;
      dv_numb_r[j] <= dv_numb_r[j-1] << 1;
      dv_rema_r[j] <= gea ? dfa[qrs_pkg::DEN_W-1:0] : rsha[qrs_pkg::DEN_W-1:0];
      dv_remb_r[j] <= geb ? dfb[qrs_pkg::DEN_W-1:0] : rshb[qrs_pkg::DEN_W-1:0];
      dv_quoa_r[j] <= {dv_quoa_r[j-1][qrs_pkg::QUO_W-2:0], gea};
      dv_quob_r[j] <= {dv_quob_r[j-1][qrs_pkg::QUO_W-2:0], geb};
    end
  end

  // --------------------------------------------------------------------------
  // output stage: saturation and case selection
  // --------------------------------------------------------------------------
  qrs_pkg::qrs_dv_sb_t f_sb;
  logic [W:0]          f_ea, f_eb, f_ebn;
  logic                out_valid_r;
  logic [W-1:0]        out_r1r_r, out_r1r_nxt, out_r1i_r, out_r1i_nxt;
  logic [W-1:0]        out_r2r_r, out_r2r_nxt, out_r2i_r, out_r2i_nxt;
  qrs_pkg::qrs_kind_t  out_kind_r, out_kind_nxt;
  logic                out_sat_r, out_sat_nxt;

  always_comb begin
    f_sb  = dv_sb_r[qrs_pkg::QUO_W];
    f_ea  = emit_part(f_sb.sgn_a, dv_quoa_r[qrs_pkg::QUO_W]);
    f_eb  = emit_part(f_sb.sgn_b, dv_quob_r[qrs_pkg::QUO_W]);
    f_ebn = emit_part(!f_sb.na, dv_quob_r[qrs_pkg::QUO_W]);
    out_r1r_nxt = '0;
    out_r1i_nxt = '0;
    out_r2r_nxt = '0;
    out_r2i_nxt = '0;
    out_sat_nxt = 1'b0;
    if (f_sb.nosol) begin
      out_kind_nxt = qrs_pkg::KIND_NONE;
    end else if (f_sb.lin) begin
      out_r1r_nxt  = f_ea[W-1:0];
      out_r2r_nxt  = f_ea[W-1:0];
      out_sat_nxt  = f_ea[W];
      out_kind_nxt = qrs_pkg::KIND_LINEAR;
    end else if (f_sb.dneg) begin
      out_r1r_nxt  = f_ea[W-1:0];
      out_r2r_nxt  = f_ea[W-1:0];
      out_r1i_nxt  = f_eb[W-1:0];
      out_r2i_nxt  = f_ebn[W-1:0];
      out_sat_nxt  = f_ea[W] | f_eb[W] | f_ebn[W];
      out_kind_nxt = qrs_pkg::KIND_COMPLEX;
    end else begin
      out_r1r_nxt  = f_ea[W-1:0];
      out_r2r_nxt  = f_eb[W-1:0];
      out_sat_nxt  = f_ea[W] | f_eb[W];
      out_kind_nxt = f_sb.dzero ? qrs_pkg::KIND_DOUBLE : qrs_pkg::KIND_TWO_REAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_v_r[qrs_pkg::QUO_W];
    end
    out_r1r_r  <= out_r1r_nxt;
    out_r1i_r  <= out_r1i_nxt;
    out_r2r_r  <= out_r2r_nxt;
    out_r2i_r  <= out_r2i_nxt;
    out_kind_r <= out_kind_nxt;
    out_sat_r  <= out_sat_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_root1_real = out_r1r_r;
  assign out_root1_imag = out_r1i_r;
  assign out_root2_real = out_r2r_r;
  assign out_root2_imag = out_r2i_r;
  assign out_root_kind  = out_kind_r;
  assign out_saturated  = out_sat_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  // every result strobe traces back to a transaction a fixed latency earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, qrs_pkg::LATENCY))
    else $error("result strobe without matching transaction");

  // no solution gives all-zero roots and no clipping
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_root_kind == qrs_pkg::KIND_NONE) |->
      (out_root1_real == '0 && out_root2_real == '0 && out_root1_imag == '0 &&
       out_root2_imag == '0 && !out_saturated))
    else $error("no-solution result not zero");

  // real and linear results carry no imaginary part
  a_real_imag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_root_kind == qrs_pkg::KIND_TWO_REAL ||
                   out_root_kind == qrs_pkg::KIND_DOUBLE ||
                   out_root_kind == qrs_pkg::KIND_LINEAR)) |->
      (out_root1_imag == '0 && out_root2_imag == '0))
    else $error("real root with imaginary part");

  // double, linear and complex cases share one real part
  a_same_real: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_root_kind == qrs_pkg::KIND_DOUBLE ||
                   out_root_kind == qrs_pkg::KIND_LINEAR ||
                   out_root_kind == qrs_pkg::KIND_COMPLEX)) |->
      (out_root1_real == out_root2_real))
    else $error("real parts differ where they must match");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the quadratic root solver
// Drives coefficient sets through a directed table and then random
// transactions with random gaps, predicts the roots with a wide integer
// model or the table, compares every result with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int W = qrs_pkg::DATA_WIDTH;
  localparam int N_RAND = 1030;

  // handy coefficient values
  localparam logic [W-1:0] ONE  = W'(1) << qrs_pkg::FRAC_BITS;
  localparam logic [W-1:0] MAXP = {1'b0, {(W - 1){1'b1}}};
  localparam logic [W-1:0] MINN = {1'b1, {(W - 1){1'b0}}};

  typedef struct {
    logic [W-1:0]       r1r, r1i, r2r, r2i;
    qrs_pkg::qrs_kind_t kind;
    logic               sat;
  } roots_t;

  typedef struct {
    logic [W-1:0] a, b, c;
    logic         has_exp;
    roots_t       exp;
  } coef_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic signed [W-1:0] in_coef_a = '0, in_coef_b = '0, in_coef_c = '0;
  logic         out_valid;
  logic signed [W-1:0] out_root1_real, out_root1_imag, out_root2_real, out_root2_imag;
  logic [2:0]   out_root_kind;
  logic         out_saturated;

  roots_t    pending_roots[$];
  coef_row_t dir_rows[$];
  int        n_err = 0;
  int        n_seen = 0;
  int        n_sent = 0;
  int        kind_cnt[5];

  quadratic_root_solver u_dut (
    .clk, .rst_n, .start, .busy, .in_coef_a, .in_coef_b, .in_coef_c,
    .out_valid, .out_root1_real, .out_root1_imag, .out_root2_real,
    .out_root2_imag, .out_root_kind, .out_saturated
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // clip a sign-magnitude value to the output range
  function automatic logic [W-1:0] clip_part(input logic neg, input logic [255:0] mag,
                                             inout logic sat);
    logic [255:0] lim;
    lim = neg ? (256'd1 << (W - 1)) : ((256'd1 << (W - 1)) - 1);
    if (mag == 0) return '0;
    if (mag > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    return neg ? W'(-mag[W-1:0]) : mag[W-1:0];
  endfunction

  // wide-integer root calculation
  function automatic roots_t solve_roots(input logic [W-1:0] a, b, c);
    roots_t r;
    logic na, nb, nc, dneg, mb, n1, n2;
    logic [255:0] am, bm, cm, den, bb, ac4, d, s, q1, q2, r1, r2, rem;
    r = '{kind: qrs_pkg::KIND_NONE, default: '0};
    na = a[W-1]; nb = b[W-1]; nc = c[W-1];
    am = na ? 256'(-a) : 256'(a);
    bm = nb ? 256'(-b) : 256'(b);
    cm = nc ? 256'(-c) : 256'(c);
    am &= (256'd1 << W) - 1; bm &= (256'd1 << W) - 1; cm &= (256'd1 << W) - 1;
    if (am == 0) begin
      if (bm != 0) begin
        q1 = (cm << qrs_pkg::FRAC_BITS) / bm;
        r.r1r = clip_part(nc == nb, q1, r.sat);
        r.r2r = r.r1r;
        r.kind = qrs_pkg::KIND_LINEAR;
      end
      return r;
    end
    den = am << 1;
    bb = bm * bm;
    ac4 = (am * cm) << 2;
    // sign of 4ac is that of a*c; d = bb - 4ac
    if ((na != nc) && cm != 0) begin
      d = bb + ac4; dneg = 1'b0;
    end else if (bb >= ac4) begin
      d = bb - ac4; dneg = 1'b0;
    end else begin
      d = ac4 - bb; dneg = 1'b1;
    end
    // floor square root by binary search on bits
    s = 0;
    for (int i = 127; i >= 0; i--) begin
      rem = s | (256'd1 << i);
      if (rem * rem <= d) s = rem;
    end
    mb = !nb && bm != 0;
    if (dneg) begin
      q1 = (bm << qrs_pkg::FRAC_BITS) / den;
      q2 = (s << qrs_pkg::FRAC_BITS) / den;
      r.r1r = clip_part(mb != na, q1, r.sat);
      r.r2r = r.r1r;
      r.r1i = clip_part(na, q2, r.sat);
      r.r2i = clip_part(!na, q2, r.sat);
      r.kind = qrs_pkg::KIND_COMPLEX;
    end else begin
      // -b + s and -b - s in sign-magnitude
      if (!mb) begin r1 = bm + s; n1 = 1'b0; end
      else if (bm >= s) begin r1 = bm - s; n1 = 1'b1; end
      else begin r1 = s - bm; n1 = 1'b0; end
      if (mb) begin r2 = bm + s; n2 = 1'b1; end
      else if (bm >= s) begin r2 = bm - s; n2 = 1'b0; end
      else begin r2 = s - bm; n2 = 1'b1; end
      q1 = (r1 << qrs_pkg::FRAC_BITS) / den;
      q2 = (r2 << qrs_pkg::FRAC_BITS) / den;
      r.r1r = clip_part(n1 != na, q1, r.sat);
      r.r2r = clip_part(n2 != na, q2, r.sat);
      r.kind = (d == 0) ? qrs_pkg::KIND_DOUBLE : qrs_pkg::KIND_TWO_REAL;
    end
    return r;
  endfunction

  function automatic logic [W-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return {1'b1, {(W - 1){1'b0}}};
      2: return {1'b0, {(W - 1){1'b1}}};
      3: return W'($signed($urandom_range(0, 8'hff) << qrs_pkg::FRAC_BITS) >>> 4);
      4: return W'($urandom_range(0, 1) ? -$urandom_range(0, 255) : $urandom_range(0, 255));
      5: return W'($signed(W'($urandom_range(0, 32'hffff))) - 32'sh8000);
      6: return W'(($urandom_range(0, 1) ? -1 : 1) *
                   ($urandom_range(1, 20) << qrs_pkg::FRAC_BITS));
      default: return W'($urandom());
    endcase
  endfunction

  task automatic add_row(input logic [W-1:0] a, b, c, input logic has,
                         input logic [W-1:0] r1r, r1i, r2r, r2i,
                         input qrs_pkg::qrs_kind_t k, input logic sat);
    coef_row_t row;
    row.a = a; row.b = b; row.c = c; row.has_exp = has;
    row.exp = '{r1r, r1i, r2r, r2i, k, sat};
    dir_rows.push_back(row);
  endtask

  // send one transaction after a random gap
  task automatic send_coefs(input logic [W-1:0] a, b, c, input roots_t exp);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_coef_a <= a; in_coef_b <= b; in_coef_c <= c;
    pending_roots.push_back(exp);
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  // stimulus
  initial begin
    roots_t pr;
    logic [W-1:0] a, b, c;
    // a and b zero: no solution
    add_row(0, 0, 0, 1, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(0, 0, MAXP, 1, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    // linear: x + 2 = 0 gives -2
    add_row(0, ONE, 2 * ONE, 1, -2 * ONE, 0, -2 * ONE, 0, qrs_pkg::KIND_LINEAR, 0);
    add_row(0, 1, MAXP, 1, MINN, 0, MINN, 0, qrs_pkg::KIND_LINEAR, 1);
    add_row(0, MINN, MAXP, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    // x^2 - 1: roots 1 and -1
    add_row(ONE, 0, -ONE, 1, ONE, 0, -ONE, 0, qrs_pkg::KIND_TWO_REAL, 0);
    // x^2 + 1: roots +-i
    add_row(ONE, 0, ONE, 1, 0, ONE, 0, -ONE, qrs_pkg::KIND_COMPLEX, 0);
    // x^2 - 2x + 1: double root 1
    add_row(ONE, -2 * ONE, ONE, 1, ONE, 0, ONE, 0, qrs_pkg::KIND_DOUBLE, 0);
    add_row(ONE, 0, 0, 1, 0, 0, 0, 0, qrs_pkg::KIND_DOUBLE, 0);
    add_row(MINN, MINN, MINN, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(MAXP, MAXP, MAXP, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(MINN, MAXP, MAXP, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(1, MAXP, MINN, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(1, 0, MAXP, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(-1, 3, -1, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(MAXP, 0, MINN, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(-ONE, 1, 0, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(0, -1, MINN, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(32'hffffffff, 32'hffffffff, 32'hffffffff, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);
    add_row(32'h55555555, 32'haaaaaaaa, 32'h55555555, 0, 0, 0, 0, 0, qrs_pkg::KIND_NONE, 0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      pr = solve_roots(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c);
      if (dir_rows[i].has_exp) pr = dir_rows[i].exp;
      send_coefs(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, pr);
    end

    // random part, a few burst-free stretches included
    for (int i = 0; i < N_RAND; i++) begin
      a = rand_coef(); b = rand_coef(); c = rand_coef();
      send_coefs(a, b, c, solve_roots(a, b, c));
    end
    start <= 1'b0;

    while (pending_roots.size() != 0) @(posedge clk);
    repeat (qrs_pkg::LATENCY + 10) @(posedge clk);
    $display("%0d transactions sent, %0d results checked", n_sent, n_seen);
    $display("kinds two_real=%0d double=%0d complex=%0d linear=%0d none=%0d",
             kind_cnt[0], kind_cnt[1], kind_cnt[2], kind_cnt[3], kind_cnt[4]);
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result checking
  always @(posedge clk) begin
    roots_t e;
    if (rst_n && out_valid) begin
      n_seen <= n_seen + 1;
      if (pending_roots.size() == 0) begin
        $display("%0t unexpected result kind %0d", $time, out_root_kind);
        n_err <= n_err + 1;
      end else begin
        e = pending_roots.pop_front();
        if (out_root_kind < 5) kind_cnt[out_root_kind]++;
        if (out_root1_real !== e.r1r || out_root1_imag !== e.r1i ||
            out_root2_real !== e.r2r || out_root2_imag !== e.r2i ||
            out_root_kind !== e.kind || out_saturated !== e.sat) begin
          $display("%0t mismatch exp %h %h %h %h k%0d s%0d act %h %h %h %h k%0d s%0d",
                   $time, e.r1r, e.r1i, e.r2r, e.r2i, e.kind, e.sat,
                   out_root1_real, out_root1_imag, out_root2_real, out_root2_imag,
                   out_root_kind, out_saturated);
          n_err <= n_err + 1;
        end
      end
    end
  end

  // watchdog
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ files.f @@
design/qrs_pkg.sv
design/quadratic_root_solver.sv
dv/tb_top.sv
